>>> rtl/swbs_pkg.sv
// Shared types and constants of the two-dimensional sliding window box sum.
package swbs_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int IMG_REG_W  = 11;
    localparam int WIN_REG_W  = 5;
    localparam int SUM_W      = 24;
    localparam int OUT_POS_W  = 10;

    localparam logic [IMG_REG_W-1:0] RESET_IMAGE_SIZE  = 11'd8;
    localparam logic [WIN_REG_W-1:0] RESET_WINDOW_SIZE = 5'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_SIZE  = 2'd0,
        REG_WINDOW_SIZE = 2'd1
    } cfg_reg_t;

    // Decisions taken at acceptance and carried with the word to the accumulate stage.
    typedef struct packed {
        logic                 use_col;
        logic                 sub_row;
        logic                 first_col;
        logic                 sub_col;
        logic                 emit;
        logic                 last;
        logic                 fwd_cs;
        logic                 fwd_hist;
        logic [OUT_POS_W-1:0] out_row;
        logic [OUT_POS_W-1:0] out_col;
    } swbs_stage_t;

endpackage

>>> rtl/sliding_window_box_sum_2d.sv
// Top level of the streaming two-dimensional box sum over valid windows.
//
//   Channel   Ports                                           Direction
//   config    cfg_we, cfg_index, cfg_data                     in, write only
//   pixels    s_valid, s_ready, s_pixel_value, s_frame_start  in
//   sums      m_valid, m_ready, m_window_sum, m_out_row,      out
//             m_out_col, m_frame_last
//
// One pixel word is taken per cycle unless the input stalls; its window sum, if any,
// goes through the first pipeline register and then the result register. The line and
// column sum memory reads are registered; write-back happens as the word leaves stage p1.
// Reset is synchronous; the memories are not cleared and need no sweep.
// A held result stalls the input only when the word behind it also carries a result.
module sliding_window_box_sum_2d import swbs_pkg::*; #(
    parameter int MAX_IMAGE_SIZE = 1024,
    parameter int MAX_WINDOW     = 16,
    parameter int PIXEL_BITS     = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [PIXEL_BITS-1:0] s_pixel_value,
    input  logic                         s_frame_start,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [SUM_W-1:0]      m_window_sum,
    output logic [OUT_POS_W-1:0]         m_out_row,
    output logic [OUT_POS_W-1:0]         m_out_col,
    output logic                         m_frame_last
);

    localparam int POS_W = $clog2(MAX_IMAGE_SIZE);
    localparam int HW    = $clog2(MAX_WINDOW);
    localparam int HA_W  = HW + POS_W;
    localparam int CS_W  = PIXEL_BITS + HW + 1;

    logic                         p1_adv, rd_en, p1_valid;
    logic [POS_W-1:0]             cs_raddr, p1_col;
    logic [HA_W-1:0]              hist_raddr;
    swbs_stage_t                  p1_info;
    logic [HW-1:0]                p1_slot, p1_rslot_new, p1_rslot_old;
    logic signed [PIXEL_BITS-1:0] p1_px;
    logic [CS_W-1:0]              cs_rdata, cs_wdata;
    logic [PIXEL_BITS-1:0]        hist_rdata, hist_wdata;

    swbs_ctrl #(
        .MAX_IMAGE_SIZE(MAX_IMAGE_SIZE),
        .MAX_WINDOW    (MAX_WINDOW),
        .PIXEL_BITS    (PIXEL_BITS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_value(s_pixel_value),
        .s_frame_start(s_frame_start),
        .p1_adv       (p1_adv),
        .rd_en        (rd_en),
        .cs_raddr     (cs_raddr),
        .hist_raddr   (hist_raddr),
        .p1_valid     (p1_valid),
        .p1_info      (p1_info),
        .p1_col       (p1_col),
        .p1_slot      (p1_slot),
        .p1_rslot_new (p1_rslot_new),
        .p1_rslot_old (p1_rslot_old),
        .p1_px        (p1_px)
    );

    swbs_ram #(
        .WIDTH(CS_W),
        .DEPTH(1 << POS_W)
    ) u_col_sums (
        .aclk (aclk),
        .we   (p1_adv),
        .waddr(p1_col),
        .wdata(cs_wdata),
        .re   (rd_en),
        .raddr(cs_raddr),
        .rdata(cs_rdata)
    );

    swbs_ram #(
        .WIDTH(PIXEL_BITS),
        .DEPTH(1 << HA_W)
    ) u_row_hist (
        .aclk (aclk),
        .we   (p1_adv),
        .waddr({p1_slot, p1_col}),
        .wdata(hist_wdata),
        .re   (rd_en),
        .raddr(hist_raddr),
        .rdata(hist_rdata)
    );

    swbs_accum #(
        .MAX_WINDOW(MAX_WINDOW),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .p1_valid    (p1_valid),
        .p1_info     (p1_info),
        .p1_rslot_new(p1_rslot_new),
        .p1_rslot_old(p1_rslot_old),
        .p1_px       (p1_px),
        .cs_rdata    (cs_rdata),
        .hist_rdata  (hist_rdata),
        .p1_adv      (p1_adv),
        .cs_wdata    (cs_wdata),
        .hist_wdata  (hist_wdata),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_window_sum(m_window_sum),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_frame_last(m_frame_last)
    );

endmodule

>>> rtl/swbs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module swbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/swbs_ctrl.sv
// Configuration, raster position tracking, memory read addressing and the first pipeline register.
module swbs_ctrl import swbs_pkg::*; #(
    parameter int MAX_IMAGE_SIZE = 1024,
    parameter int MAX_WINDOW     = 16,
    parameter int PIXEL_BITS     = 16,
    localparam int POS_W  = $clog2(MAX_IMAGE_SIZE),
    localparam int HW     = $clog2(MAX_WINDOW),
    localparam int HA_W   = HW + POS_W
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [PIXEL_BITS-1:0] s_pixel_value,
    input  logic                         s_frame_start,
    input  logic                         p1_adv,
    output logic                         rd_en,
    output logic [POS_W-1:0]             cs_raddr,
    output logic [HA_W-1:0]              hist_raddr,
    output logic                         p1_valid,
    output swbs_stage_t                  p1_info,
    output logic [POS_W-1:0]             p1_col,
    output logic [HW-1:0]                p1_slot,
    output logic [HW-1:0]                p1_rslot_new,
    output logic [HW-1:0]                p1_rslot_old,
    output logic signed [PIXEL_BITS-1:0] p1_px
);

    localparam int NW    = $clog2(MAX_IMAGE_SIZE + 1);
    localparam int MW_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUBW  = POS_W + MW_W;
    localparam int CMP_W = NW + MW_W;

    function automatic logic [NW-1:0] clamp_n(input logic [IMG_REG_W-1:0] v);
        logic [NW-1:0] res;
        if (v == '0) begin
            res = NW'(1);
        end else if (32'(v) > 32'(MAX_IMAGE_SIZE)) begin
            res = NW'(MAX_IMAGE_SIZE);
        end else begin
            res = NW'(v);
        end
        return res;
    endfunction

    function automatic logic [MW_W-1:0] clamp_m(input logic [WIN_REG_W-1:0] v);
        logic [MW_W-1:0] res;
        if (v == '0) begin
            res = MW_W'(1);
        end else if (32'(v) > 32'(MAX_WINDOW)) begin
            res = MW_W'(MAX_WINDOW);
        end else begin
            res = MW_W'(v);
        end
        return res;
    endfunction

    logic [NW-1:0]       eff_n_reg;
    logic [MW_W-1:0]     eff_m_reg;
    logic [POS_W-1:0]    row_pos_reg, row_pos_next;
    logic [POS_W-1:0]    col_pos_reg, col_pos_next;
    logic                p1_valid_reg, p1_valid_next;
    swbs_stage_t         p1_info_reg, p1_info_next;
    logic [POS_W-1:0]    p1_col_reg;
    logic [HW-1:0]       p1_slot_reg, p1_rslot_new_reg, p1_rslot_old_reg;
    logic signed [PIXEL_BITS-1:0] p1_px_reg;

    logic                acc;
    logic [POS_W-1:0]    r_sel, c_sel, r, c;
    logic [NW-1:0]       r1, c1;
    logic [SUBW-1:0]     rx, cx, rdiff, cdiff;
    logic [CMP_W-1:0]    orow, ocol;
    logic [HW-1:0]       slot_new, slot_old, rslot_new, rslot_old;

    assign s_ready = !p1_valid_reg || p1_adv;
    assign acc     = s_valid && s_ready;

    always_comb begin
        r_sel = s_frame_start ? '0 : row_pos_reg;
        c_sel = s_frame_start ? '0 : col_pos_reg;
        r     = (NW'(r_sel) >= eff_n_reg) ? '0 : r_sel;
        c     = (NW'(c_sel) >= eff_n_reg) ? '0 : c_sel;
        r1    = NW'(r) + NW'(1);
        c1    = NW'(c) + NW'(1);

        rx        = SUBW'(r);
        cx        = SUBW'(c);
        rdiff     = rx - SUBW'(eff_m_reg);
        cdiff     = cx - SUBW'(eff_m_reg);
        slot_new  = rx[HW-1:0];
        slot_old  = rdiff[HW-1:0];
        rslot_new = cx[HW-1:0];
        rslot_old = cdiff[HW-1:0];

        orow = CMP_W'(r1) - CMP_W'(eff_m_reg);
        ocol = CMP_W'(c1) - CMP_W'(eff_m_reg);

        p1_info_next.use_col   = (r != '0);
        p1_info_next.sub_row   = (CMP_W'(r) >= CMP_W'(eff_m_reg));
        p1_info_next.first_col = (c == '0);
        p1_info_next.sub_col   = (CMP_W'(c) >= CMP_W'(eff_m_reg));
        p1_info_next.emit      = (CMP_W'(eff_m_reg) <= CMP_W'(eff_n_reg))
                              && (CMP_W'(r1) >= CMP_W'(eff_m_reg))
                              && (CMP_W'(c1) >= CMP_W'(eff_m_reg));
        p1_info_next.last      = (r1 == eff_n_reg) && (c1 == eff_n_reg);
        p1_info_next.fwd_cs    = p1_valid_reg && p1_adv && (p1_col_reg == c);
        p1_info_next.fwd_hist  = p1_valid_reg && p1_adv && (p1_col_reg == c)
                              && (p1_slot_reg == slot_old);
        p1_info_next.out_row   = OUT_POS_W'(orow);
        p1_info_next.out_col   = OUT_POS_W'(ocol);

        if (c1 >= eff_n_reg) begin
            col_pos_next = '0;
            row_pos_next = (r1 >= eff_n_reg) ? '0 : POS_W'(r1);
        end else begin
            col_pos_next = POS_W'(c1);
            row_pos_next = r;
        end

        if (acc) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_n_reg    <= clamp_n(RESET_IMAGE_SIZE);
            eff_m_reg    <= clamp_m(RESET_WINDOW_SIZE);
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            if (acc) begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
            end
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_SIZE: begin
                        eff_n_reg   <= clamp_n(cfg_data[IMG_REG_W-1:0]);
                        row_pos_reg <= '0;
                        col_pos_reg <= '0;
                    end
                    REG_WINDOW_SIZE: begin
                        eff_m_reg   <= clamp_m(cfg_data[WIN_REG_W-1:0]);
                        row_pos_reg <= '0;
                        col_pos_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            p1_info_reg      <= p1_info_next;
            p1_col_reg       <= c;
            p1_slot_reg      <= slot_new;
            p1_rslot_new_reg <= rslot_new;
            p1_rslot_old_reg <= rslot_old;
            p1_px_reg        <= s_pixel_value;
        end
    end

    assign rd_en        = acc;
    assign cs_raddr     = c;
    assign hist_raddr   = {slot_old, c};
    assign p1_valid     = p1_valid_reg;
    assign p1_info      = p1_info_reg;
    assign p1_col       = p1_col_reg;
    assign p1_slot      = p1_slot_reg;
    assign p1_rslot_new = p1_rslot_new_reg;
    assign p1_rslot_old = p1_rslot_old_reg;
    assign p1_px        = p1_px_reg;

    // The stored position always lies inside the current image.
    a_pos_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        (NW'(row_pos_reg) < eff_n_reg) && (NW'(col_pos_reg) < eff_n_reg))
        else $error("raster position outside the image");

endmodule

>>> rtl/swbs_accum.sv
// Column sum and running window sum update, memory write-back and the result register.
module swbs_accum import swbs_pkg::*; #(
    parameter int MAX_WINDOW = 16,
    parameter int PIXEL_BITS = 16,
    localparam int HW        = $clog2(MAX_WINDOW),
    localparam int CS_W      = PIXEL_BITS + HW + 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         p1_valid,
    input  swbs_stage_t                  p1_info,
    input  logic [HW-1:0]                p1_rslot_new,
    input  logic [HW-1:0]                p1_rslot_old,
    input  logic signed [PIXEL_BITS-1:0] p1_px,
    input  logic [CS_W-1:0]              cs_rdata,
    input  logic [PIXEL_BITS-1:0]        hist_rdata,
    output logic                         p1_adv,
    output logic [CS_W-1:0]              cs_wdata,
    output logic [PIXEL_BITS-1:0]        hist_wdata,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [SUM_W-1:0]      m_window_sum,
    output logic [OUT_POS_W-1:0]         m_out_row,
    output logic [OUT_POS_W-1:0]         m_out_col,
    output logic                         m_frame_last
);

    localparam int RS_W   = CS_W + HW;
    localparam int SUMX_W = (RS_W > SUM_W) ? RS_W : SUM_W;
    localparam int RDEPTH = 1 << HW;

    logic signed [RS_W-1:0]       run_reg;
    logic signed [CS_W-1:0]       recent_reg [RDEPTH];
    logic signed [CS_W-1:0]       last_cs_reg;
    logic signed [PIXEL_BITS-1:0] last_px_reg;
    logic                         m_valid_reg;
    logic signed [SUM_W-1:0]      m_window_sum_reg;
    logic [OUT_POS_W-1:0]         m_out_row_reg, m_out_col_reg;
    logic                         m_frame_last_reg;

    logic signed [CS_W-1:0]       csum_rd, hist_term, cs_val, recent_rd;
    logic signed [PIXEL_BITS-1:0] hist_rd;
    logic signed [RS_W-1:0]       recent_term, run_val;
    logic signed [SUMX_W-1:0]     sum_x;
    logic                         load_out;

    assign p1_adv   = p1_valid && (!p1_info.emit || !m_valid_reg || m_ready);
    assign load_out = p1_adv && p1_info.emit;

    always_comb begin
        csum_rd = p1_info.fwd_cs ? last_cs_reg : signed'(cs_rdata);
        hist_rd = p1_info.fwd_hist ? last_px_reg : signed'(hist_rdata);
        if (p1_info.sub_row) begin
            hist_term = CS_W'(hist_rd);
        end else begin
            hist_term = '0;
        end
        if (p1_info.use_col) begin
            cs_val = csum_rd + CS_W'(p1_px) - hist_term;
        end else begin
            cs_val = CS_W'(p1_px);
        end

        recent_rd = recent_reg[p1_rslot_old];
        if (p1_info.sub_col) begin
            recent_term = RS_W'(recent_rd);
        end else begin
            recent_term = '0;
        end
        if (p1_info.first_col) begin
            run_val = RS_W'(cs_val);
        end else begin
            run_val = run_reg + RS_W'(cs_val) - recent_term;
        end
        sum_x = SUMX_W'(run_val);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < RDEPTH; i++) begin
                recent_reg[i] <= '0;
            end
        end else begin
            if (p1_adv) begin
                run_reg                  <= run_val;
                recent_reg[p1_rslot_new] <= cs_val;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            last_cs_reg <= cs_val;
            last_px_reg <= p1_px;
        end
        if (load_out) begin
            m_window_sum_reg <= sum_x[SUM_W-1:0];
            m_out_row_reg    <= p1_info.out_row;
            m_out_col_reg    <= p1_info.out_col;
            m_frame_last_reg <= p1_info.last;
        end
    end

    assign cs_wdata     = cs_val;
    assign hist_wdata   = p1_px;
    assign m_valid      = m_valid_reg;
    assign m_window_sum = m_window_sum_reg;
    assign m_out_row    = m_out_row_reg;
    assign m_out_col    = m_out_col_reg;
    assign m_frame_last = m_frame_last_reg;

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid_reg)
        else $error("finished window sum not presented");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !load_out)
        else $error("waiting result overwritten");

    a_last_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_frame_last_reg) |-> (m_out_row_reg == m_out_col_reg))
        else $error("last window of a square image off the diagonal");

endmodule

>>> test/box_sum_checker.sv
// Checker for the 2D box sum: predicts each window sum from the observed words and compares.
module box_sum_checker import swbs_pkg::*; #(
    parameter int IMG_MAX = 1024,
    parameter int WIN_MAX = 16,
    parameter int PIX_W   = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic signed [PIX_W-1:0] s_pixel_value,
    input  logic                    s_frame_start,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [SUM_W-1:0] m_window_sum,
    input  logic [OUT_POS_W-1:0]    m_out_row,
    input  logic [OUT_POS_W-1:0]    m_out_col,
    input  logic                    m_frame_last,
    output int                      fail_count,
    output int                      sums_pending
);

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [OUT_POS_W-1:0]    row;
        logic [OUT_POS_W-1:0]    col;
        logic                    last;
    } window_result_t;

    window_result_t       expected_sums[$];
    int                   line_pixels [0:WIN_MAX*IMG_MAX-1];
    int                   column_totals [0:IMG_MAX-1];
    int                   recent_totals [0:WIN_MAX-1];
    int                   row_total;
    int                   cur_row;
    int                   cur_col;
    logic [IMG_REG_W-1:0] side_reg;
    logic [WIN_REG_W-1:0] win_reg;
    int                   mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what);
        if (mismatches < 40) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        mismatches++;
    endtask

    task automatic predict_window(input logic signed [PIX_W-1:0] px, input logic restart);
        int             n;
        int             m;
        int             r;
        int             c;
        int             col_total;
        window_result_t want;
        n = (side_reg == 0) ? 1 : (side_reg > IMG_MAX) ? IMG_MAX : int'(side_reg);
        m = (win_reg == 0) ? 1 : (win_reg > WIN_MAX) ? WIN_MAX : int'(win_reg);
        if (restart) begin
            cur_row = 0;
            cur_col = 0;
        end
        if (cur_row >= n) begin
            cur_row = 0;
        end
        if (cur_col >= n) begin
            cur_col = 0;
        end
        r = cur_row;
        c = cur_col;
        // Each column keeps the total of its last m pixels; the row keeps the last m totals.
        if (r == 0) begin
            col_total = px;
        end else begin
            col_total = column_totals[c] + px;
            if (r >= m) begin
                col_total -= line_pixels[((r - m) % WIN_MAX) * IMG_MAX + c];
            end
        end
        column_totals[c] = col_total;
        line_pixels[(r % WIN_MAX) * IMG_MAX + c] = px;
        if (c == 0) begin
            row_total = col_total;
        end else begin
            row_total += col_total;
            if (c >= m) begin
                row_total -= recent_totals[(c - m) % WIN_MAX];
            end
        end
        recent_totals[c % WIN_MAX] = col_total;
        if (m <= n && r + 1 >= m && c + 1 >= m) begin
            want.sum  = row_total[SUM_W-1:0];
            want.row  = OUT_POS_W'(r + 1 - m);
            want.col  = OUT_POS_W'(c + 1 - m);
            want.last = (r == n - 1 && c == n - 1);
            expected_sums.push_back(want);
        end
        if (c + 1 >= n) begin
            cur_col = 0;
            cur_row = (r + 1 >= n) ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
        end
    endtask

    task automatic check_sum();
        window_result_t want;
        if (expected_sums.size() == 0) begin
            report_mismatch($sformatf("unexpected sum %0d at row %0d col %0d",
                                      m_window_sum, m_out_row, m_out_col));
        end else begin
            want = expected_sums.pop_front();
            if (m_window_sum !== want.sum) begin
                report_mismatch($sformatf("window_sum %0d, expected %0d (row %0d col %0d)",
                                          m_window_sum, want.sum, want.row, want.col));
            end
            if (m_out_row !== want.row) begin
                report_mismatch($sformatf("out_row %0d, expected %0d", m_out_row, want.row));
            end
            if (m_out_col !== want.col) begin
                report_mismatch($sformatf("out_col %0d, expected %0d", m_out_col, want.col));
            end
            if (m_frame_last !== want.last) begin
                report_mismatch($sformatf("frame_last %0b, expected %0b at row %0d col %0d",
                                          m_frame_last, want.last, want.row, want.col));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_sums.delete();
            side_reg  = RESET_IMAGE_SIZE;
            win_reg   = RESET_WINDOW_SIZE;
            cur_row   = 0;
            cur_col   = 0;
            row_total = 0;
            foreach (recent_totals[i]) begin
                recent_totals[i] = 0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_IMAGE_SIZE: begin
                        side_reg = cfg_data[IMG_REG_W-1:0];
                        cur_row  = 0;
                        cur_col  = 0;
                    end
                    REG_WINDOW_SIZE: begin
                        win_reg = cfg_data[WIN_REG_W-1:0];
                        cur_row = 0;
                        cur_col = 0;
                    end
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                check_sum();
            end
            if (s_valid && s_ready) begin
                predict_window(s_pixel_value, s_frame_start);
            end
        end
        sums_pending <= expected_sums.size();
    end

endmodule

>>> test/tb_top.sv
// Top of the 2D box sum testbench: clock, reset, register writes, pixel and sum drivers.
module tb_top;
    import swbs_pkg::*;

    localparam int PIX_W       = 16;
    localparam int WORD_TARGET = 1576;
    localparam int HOLD_CYCLES = 300;

    localparam logic [CFG_IDX_W-1:0]    REG_SPARE = 2'd2;
    localparam logic signed [PIX_W-1:0] PIX_MAX   = 16'sh7FFF;
    localparam logic signed [PIX_W-1:0] PIX_MIN   = 16'sh8000;

    typedef enum {PIX_RANDOM, PIX_ALL_MAX, PIX_ALL_MIN} pixel_mix_t;
    typedef enum {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = REG_IMAGE_SIZE;
    logic [CFG_DATA_W-1:0]   cfg_data      = '0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic signed [PIX_W-1:0] s_pixel_value = '0;
    logic                    s_frame_start = 1'b0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic signed [SUM_W-1:0] m_window_sum;
    logic [OUT_POS_W-1:0]    m_out_row;
    logic [OUT_POS_W-1:0]    m_out_col;
    logic                    m_frame_last;

    int    fail_count;
    int    sums_pending;
    int    words_sent = 0;
    int    hold_left  = 0;
    int    holds_done = 0;
    pace_t pace       = PACE_SLOW_SINK;

    always #2 aclk = ~aclk;

    sliding_window_box_sum_2d DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_window_sum  (m_window_sum),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_frame_last  (m_frame_last)
    );

    box_sum_checker sum_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_window_sum  (m_window_sum),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_frame_last  (m_frame_last),
        .fail_count    (fail_count),
        .sums_pending  (sums_pending)
    );

    function automatic int source_idle_pct();
        return (pace == PACE_SLOW_SINK) ? 37 : (pace == PACE_SLOW_SOURCE) ? 85 : 0;
    endfunction

    function automatic int sink_idle_pct();
        return (pace == PACE_SLOW_SINK) ? 85 : (pace == PACE_SLOW_SOURCE) ? 37 : 0;
    endfunction

    // The sink is held off twice for a long stretch while a sum is waiting, so that the
    // block fills up and has to stall the pixel side.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && m_valid && words_sent >= 700 + 600 * holds_done) begin
            m_ready    <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct());
        end
    end

    task automatic send_word(input logic signed [PIX_W-1:0] px, input logic restart);
        while ($urandom_range(99) < source_idle_pct()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_value <= px;
        s_frame_start <= restart;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        pace = (words_sent < WORD_TARGET / 3) ? PACE_SLOW_SINK :
               (words_sent < 2 * WORD_TARGET / 3) ? PACE_SLOW_SOURCE : PACE_FULL;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sums_pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input int side, input int win);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_SIZE;
        cfg_data  <= CFG_DATA_W'(side);
        @(posedge aclk);
        cfg_index <= REG_WINDOW_SIZE;
        cfg_data  <= CFG_DATA_W'(win);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int side, input int win, input int count,
                             input pixel_mix_t mix, input logic keep_geometry);
        int                      n;
        int                      k;
        logic signed [PIX_W-1:0] px;
        logic                    restart;
        n = (side == 0) ? 1 : (side > 1024) ? 1024 : side;
        settle();
        if (keep_geometry) begin
            // A write to an unused index must leave the position in the frame alone.
            cfg_we    <= 1'b1;
            cfg_index <= REG_SPARE;
            cfg_data  <= CFG_DATA_W'($urandom);
            @(posedge aclk);
            cfg_we <= 1'b0;
        end else begin
            configure(side, win);
        end
        for (k = 0; k < count; k++) begin
            case (mix)
                PIX_ALL_MAX: px = PIX_MAX;
                PIX_ALL_MIN: px = PIX_MIN;
                default: begin
                    case ($urandom_range(9))
                        0:       px = PIX_MAX;
                        1:       px = PIX_MIN;
                        default: px = PIX_W'($urandom);
                    endcase
                end
            endcase
            if (k % (n * n) == 0) begin
                restart = ($urandom_range(9) < 7);
            end else begin
                restart = ($urandom_range(99) < 2);
            end
            send_word(px, restart);
        end
    endtask

    initial begin
        int p;
        int k;
        int side;
        int win;
        int roll;
        int frames;
        int count;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Two frames of extreme pixels, the second one starting by wrap-around alone.
        configure(2, 2);
        send_word(PIX_MAX, 1'b1);
        repeat (3) send_word(PIX_MAX, 1'b0);
        repeat (4) send_word(PIX_MIN, 1'b0);
        // Zero registers are taken as one: every pixel is its own final window.
        settle();
        configure(0, 0);
        send_word('0, 1'b1);
        send_word('1, 1'b0);
        // A window wider than the image gives nothing.
        settle();
        configure(2, 31);
        send_word(PIX_MAX, 1'b1);
        send_word(PIX_MIN, 1'b0);
        // A register write and a frame start both restart the position mid-image.
        settle();
        configure(3, 2);
        for (k = 0; k < 3; k++) begin
            send_word(PIX_W'($urandom), 1'b0);
        end
        settle();
        configure(3, 2);
        send_word(PIX_W'($urandom), 1'b0);
        send_word(PIX_W'($urandom), 1'b0);
        send_word(PIX_W'($urandom), 1'b1);
        for (k = 0; k < 8; k++) begin
            send_word(PIX_W'($urandom), 1'b0);
        end

        p = 0;
        while (words_sent < WORD_TARGET) begin
            case (p)
                0: run_phase(2047, 1, 48, PIX_RANDOM, 1'b0);
                1: run_phase(1024, 16, 48, PIX_RANDOM, 1'b0);
                2: run_phase(16, 16, 256, PIX_ALL_MIN, 1'b0);
                3: run_phase(4, 4, 16, PIX_ALL_MAX, 1'b0);
                4: run_phase(5, 2, 12, PIX_RANDOM, 1'b0);
                5: run_phase(5, 2, 30, PIX_RANDOM, 1'b1);
                default: begin
                    side = ($urandom_range(9) == 0) ? $urandom_range(20, 13)
                                                    : $urandom_range(12, 1);
                    roll = $urandom_range(9);
                    if (roll == 0) begin
                        win = $urandom_range(31, 0);
                    end else if (roll == 1) begin
                        win = side + 1 + $urandom_range(2, 0);
                    end else begin
                        win = $urandom_range((side < 6) ? side : 6, 1);
                    end
                    frames = 1 + $urandom_range(120 / (side * side), 0);
                    count  = frames * side * side;
                    if ($urandom_range(4) == 0) begin
                        count -= $urandom_range(side * side - 1, 0);
                    end
                    run_phase(side, win, count, PIX_RANDOM, 1'b0);
                end
            endcase
            p++;
        end

        settle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && sums_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
